// File: hw/rtl/pnc_pkg.sv
package pnc_pkg;
  localparam int WindowLenDef  = 32;
  localparam int SampleBitsDef = 16;
  localparam int ScoreBits     = 16;
  localparam int QBits         = 16;
  localparam int NumPulses     = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQ,
    ST_QQ,
    ST_MUL,
    ST_CMP,
    ST_OUT
  } pnc_state_t;

  typedef struct packed {
    logic load;      // shift in sample, update energy
    logic clear;     // empty window, then take this sample
    logic sum_step;  // add one pulse tap
    logic sq_step;   // square pulse sum, set trial bit
    logic qq_step;   // square trial value
    logic mul_step;  // form energy * trial^2
    logic cmp_step;  // keep or drop trial bit
  } pnc_cmd_t;

  typedef struct packed {
    logic full;
    logic zero_e;
    logic sat;
    logic last_tap;
    logic last_bit;
  } pnc_sts_t;

  function automatic int pulse_pos(input int i);
    case (i)
      0: return 0;
      1: return 1;
      2: return 4;
      3: return 5;
      4: return 14;
      5: return 15;
      6: return 18;
      default: return 19;
    endcase
  endfunction
endpackage

// File: hw/rtl/pnc_ctrl.sv
module pnc_ctrl
  import pnc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     in_start,
  input  pnc_sts_t sts,
  output pnc_cmd_t cmd,
  output logic     res_load
);
  pnc_state_t state_r, state_nxt;
  logic       ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r & ~out_ready;
    cmd       = '0;
    res_load  = 1'b0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.clear = in_start;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!sts.full) state_nxt = ST_IDLE;
        else begin
          cmd.sum_step = 1'b1;
          if (sts.last_tap) state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sts.zero_e || sts.sat) state_nxt = ST_OUT;
        else begin
          cmd.sq_step = 1'b1;
          state_nxt   = ST_QQ;
        end
      end
      ST_QQ: begin
        cmd.qq_step = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp_step = 1'b1;
        state_nxt    = sts.last_bit ? ST_OUT : ST_QQ;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!ov_r || out_ready) begin
          res_load  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: hw/rtl/pnc_dp.sv
module pnc_dp
  import pnc_pkg::*;
#(
  parameter int WINDOW_LEN  = WindowLenDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  pnc_cmd_t               cmd,
  input  logic                   res_load,
  output pnc_sts_t               sts,
  output logic [ScoreBits-1:0]   out_score,
  output logic                   out_zero_energy
);
  localparam int CntW = $clog2(WINDOW_LEN + 1);
  localparam int SqW  = 2 * SAMPLE_BITS;
  localparam int EW   = SqW + $clog2(WINDOW_LEN);
  localparam int SW   = SAMPLE_BITS + 3;
  localparam int S2W  = 2 * SW;
  localparam int PW   = EW + 2 * QBits;

  logic [SAMPLE_BITS-1:0] win_r [WINDOW_LEN];
  logic [CntW-1:0]        fill_r;
  logic [EW-1:0]          energy_r;
  logic [2:0]             tap_r;
  logic [SW-1:0]          sum_r;
  logic [S2W-1:0]         s2_r;
  logic [S2W-1:0]         sum_sq;
  logic [QBits-1:0]       q_r, trial_r;
  logic [3:0]             bit_r;
  logic [PW-1:0]          prod_r;
  logic [2*QBits-1:0]     qq_r;
  logic [SAMPLE_BITS-1:0] tap_val, old;
  logic [SqW-1:0]         old_sq, new_sq;
  logic [ScoreBits-1:0]   score_r;
  logic                   ze_r;

  assign old     = win_r[0];
  assign old_sq  = old * old;
  assign new_sq  = in_sample * in_sample;
  assign sum_sq  = sum_r * sum_r;

  always_comb begin
    tap_val = '0;
    for (int i = 0; i < NumPulses; i++)
      if (tap_r == 3'(i)) tap_val = win_r[pulse_pos(i)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      energy_r <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= '0;
    end else if (cmd.load) begin
      if (cmd.clear) begin
        for (int i = 1; i < WINDOW_LEN; i++) win_r[i] <= '0;
        win_r[0] <= in_sample;
        fill_r   <= CntW'(1);
        energy_r <= EW'(new_sq);
      end else if (fill_r == CntW'(WINDOW_LEN)) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) win_r[i] <= win_r[i+1];
        win_r[WINDOW_LEN-1] <= in_sample;
        energy_r <= energy_r - EW'(old_sq) + EW'(new_sq);
      end else begin
        for (int i = 0; i < WINDOW_LEN; i++)
          if (fill_r == CntW'(i)) win_r[i] <= in_sample;
        fill_r   <= fill_r + CntW'(1);
        energy_r <= energy_r + EW'(new_sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tap_r <= '0;
      sum_r <= '0;
    end
    if (cmd.sum_step) begin
      sum_r <= sum_r + SW'(tap_val);
      tap_r <= tap_r + 3'd1;
    end
    if (cmd.sq_step) begin
      s2_r    <= sum_sq;
      q_r     <= '0;
      trial_r <= QBits'(1) << (QBits - 1);
      bit_r   <= 4'(QBits - 1);
    end
    if (cmd.qq_step) qq_r <= trial_r * trial_r;
    if (cmd.mul_step) prod_r <= PW'(energy_r) * PW'(qq_r);
    if (cmd.cmp_step) begin
      // keep trial bit when E*t*t <= S*S * 2^27
      if (PW'({s2_r, 27'b0}) >= prod_r) begin
        q_r     <= trial_r;
        trial_r <= trial_r | ((QBits'(1) << bit_r) >> 1);
      end else begin
        trial_r <= q_r | ((QBits'(1) << bit_r) >> 1);
      end
      bit_r <= bit_r - 4'd1;
    end
    if (res_load) begin
      ze_r <= sts.zero_e;
      if (sts.zero_e) score_r <= '0;
      else if (sts.sat) score_r <= ScoreBits'(32768);
      else score_r <= q_r;
    end
  end

  assign sts.full     = (fill_r == CntW'(WINDOW_LEN));
  assign sts.zero_e   = (energy_r == '0);
  assign sts.sat      = {3'b0, sum_sq} >= ((S2W + 3)'(energy_r) << 3);
  assign sts.last_tap = (tap_r == 3'(NumPulses - 1));
  assign sts.last_bit = (bit_r == '0);
  assign out_score       = score_r;
  assign out_zero_energy = ze_r;
endmodule

// File: hw/rtl/preamble_normalized_correlator.sv
// channel | ports                                  | direction
// in      | in_valid in_ready in_sample in_start_of_buffer | into block
// out     | out_valid out_ready out_score out_zero_energy  | out of block
// While the window is not yet full, an item is only taken in. Otherwise it passes
// through intake, summing of 8 pulse taps, a square, 16 square/multiply/compare
// triples of the bit-by-bit square root and divide search, and the load of the
// result; zero energy or a full-scale match skips the search.
// Reset is synchronous, active low, and empties the window.
// Intake waits while a result waits for a free output register.
module preamble_normalized_correlator
  import pnc_pkg::*;
#(
  parameter int WINDOW_LEN  = WindowLenDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_start_of_buffer,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ScoreBits-1:0]   out_score,
  output logic                   out_zero_energy
);
  pnc_cmd_t cmd;
  pnc_sts_t sts;
  logic     res_load;

  pnc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .in_start(in_start_of_buffer), .sts, .cmd, .res_load
  );

  pnc_dp #(.WINDOW_LEN(WINDOW_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst_n, .in_sample, .cmd, .res_load, .sts, .out_score, .out_zero_energy
  );
endmodule

// File: hw/rtl/pnc_checker.sv
module pnc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_score,
  input logic        out_zero_energy
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_score))
    else $error("result dropped while stalled");
  a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_score <= 16'd32768)
    else $error("score above one");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_energy |-> out_score == 16'd0)
    else $error("zero energy with nonzero score");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two words back to back");
endmodule

bind preamble_normalized_correlator pnc_checker u_pnc_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_score, .out_zero_energy
);
